// ===== sv/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg - shared types for the priority ready queue scheduler
// Sizes, command codes, sequencer states and the packed words of the task
// and level memories.
// ----------------------------------------------------------------------------
package prq_pkg;

	// Field widths are fixed by the command and result beats
	localparam int TASK_W     = 6;
	localparam int LEVEL_W    = 4;
	localparam int NUM_TASKS  = 64;
	localparam int NUM_LEVELS = 16;

	// Command codes
	typedef enum logic [1:0] {
		FN_MAKE_READY = 2'd0,
		FN_REMOVE     = 2'd1,
		FN_CHG_PRI    = 2'd2,
		FN_ROTATE     = 2'd3
	} func_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_UL_TASK,
		S_UL_LVL,
		S_UL_W1,
		S_UL_W2,
		S_AP_RD,
		S_AP_W1,
		S_AP_W2,
		S_SR_RD,
		S_SR_WB,
		S_RT_LVL,
		S_RT_HD,
		S_RT_W1,
		S_RT_W2,
		S_DONE
	} state_t;

	// One entry per task: its level and its links within that level
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [TASK_W-1:0]  prev;
		logic [TASK_W-1:0]  next;
	} task_word_t;

	typedef struct packed {
		logic level;
		logic prev;
		logic next;
	} task_wen_t;

	// One entry per level: head and tail of its FIFO
	typedef struct packed {
		logic [TASK_W-1:0] head;
		logic [TASK_W-1:0] tail;
	} level_word_t;

	typedef struct packed {
		logic head;
		logic tail;
	} level_wen_t;

endpackage

// ===== sv/priority_ready_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_core - hardware ready queue for one processor
// Per-level FIFOs of task numbers as doubly linked lists in two memories,
// a bitmap of non-empty levels, and the current highest-priority pick.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and one result beat is produced for
// it. A command is worked by a sequencer that reads, modifies and writes back
// a task memory (level and links per task) and a level memory (head and tail
// per level), both with a registered read. The sequencer steps through the
// memory accesses that each list update needs; a remove of the pick, or a
// change of priority that moves the pick down or sideways, adds a search,
// a rotate of a level that holds fewer than two tasks ends early, and
// ignored commands go straight to the result. A stalled result register
// adds its wait. The next command is taken while the previous result is
// still waiting on the output. No clearing pass is needed after reset: only
// entries of non-empty levels and ready tasks are ever used.
module priority_ready_queue_scheduler_core
	import prq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command beat
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [TASK_W-1:0]  task_id,
	input  logic [LEVEL_W-1:0] priority_req,
	input  logic               dispatch_enabled,
	// result beat
	output logic               out_valid,
	input  logic               out_stall,
	output logic [TASK_W-1:0]  sched_task,
	output logic               sched_valid,
	output logic               dispatch_request
);

	// Sequencer and command registers
	state_t               state_q, state_d;
	func_t                cmd_func_q, cmd_func_d;
	logic [TASK_W-1:0]    cmd_task_q, cmd_task_d;
	logic [LEVEL_W-1:0]   cmd_pri_q, cmd_pri_d;
	logic                 cmd_en_q, cmd_en_d;

	// Scratch registers for list surgery
	logic [LEVEL_W-1:0]   old_level_q, old_level_d;
	logic [TASK_W-1:0]    ul_prev_q, ul_prev_d;
	logic [TASK_W-1:0]    ul_next_q, ul_next_d;
	logic                 ul_at_tail_q, ul_at_tail_d;
	logic                 ul_single_q, ul_single_d;
	logic [TASK_W-1:0]    ap_tail_q, ap_tail_d;
	logic                 ap_nonempty_q, ap_nonempty_d;
	logic [TASK_W-1:0]    rt_head_q, rt_head_d;
	logic [TASK_W-1:0]    rt_tail_q, rt_tail_d;
	logic [LEVEL_W-1:0]   sr_level_q, sr_level_d;

	// Scheduler state
	logic [NUM_LEVELS-1:0] ready_bitmap_q, ready_bitmap_d;
	logic [NUM_TASKS-1:0]  task_ready_q, task_ready_d;
	logic [TASK_W-1:0]     pick_q, pick_d;
	logic [LEVEL_W-1:0]    pick_level_q, pick_level_d;
	logic                  pick_valid_q, pick_valid_d;
	logic                  req_q, req_d;

	// Result register
	logic                  out_valid_q, out_valid_d;
	logic                  out_load;
	logic [TASK_W-1:0]     sched_task_q;
	logic                  sched_valid_q;
	logic                  dispatch_request_q;

	// Memory ports
	task_word_t            tm_mem [NUM_TASKS];
	logic                  tm_ren;
	logic [TASK_W-1:0]     tm_raddr;
	task_word_t            tm_rdata;
	task_wen_t             tm_wen;
	logic [TASK_W-1:0]     tm_waddr;
	task_word_t            tm_wdata;

	level_word_t           lm_mem [NUM_LEVELS];
	logic                  lm_ren;
	logic [LEVEL_W-1:0]    lm_raddr;
	level_word_t           lm_rdata;
	level_wen_t            lm_wen;
	logic [LEVEL_W-1:0]    lm_waddr;
	level_word_t           lm_wdata;

	logic                  task_ok;
	logic                  pri_ok;
	logic [LEVEL_W-1:0]    top_level;

	// Highest non-empty level (lowest set bit)
	function automatic logic [LEVEL_W-1:0] first_set(input logic [NUM_LEVELS-1:0] bits);
		logic [LEVEL_W-1:0] enc;
		enc = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (bits[i]) begin
				enc = LEVEL_W'(i);
			end
		end
		return enc;
	endfunction

	assign task_ok   = int'(task_id) < NUM_TASKS;
	assign pri_ok    = int'(priority_req) < NUM_LEVELS;
	assign top_level = first_set(ready_bitmap_q);

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign sched_task       = sched_task_q;
	assign sched_valid      = sched_valid_q;
	assign dispatch_request = dispatch_request_q;

	// Task memory: field-enabled write, registered read
	always_ff @(posedge clk) begin
		if (tm_wen.level) begin
			tm_mem[tm_waddr].level <= tm_wdata.level;
		end
		if (tm_wen.prev) begin
			tm_mem[tm_waddr].prev <= tm_wdata.prev;
		end
		if (tm_wen.next) begin
			tm_mem[tm_waddr].next <= tm_wdata.next;
		end
		if (tm_ren) begin
			tm_rdata <= tm_mem[tm_raddr];
		end
	end

	// Level memory: field-enabled write, registered read
	always_ff @(posedge clk) begin
		if (lm_wen.head) begin
			lm_mem[lm_waddr].head <= lm_wdata.head;
		end
		if (lm_wen.tail) begin
			lm_mem[lm_waddr].tail <= lm_wdata.tail;
		end
		if (lm_ren) begin
			lm_rdata <= lm_mem[lm_raddr];
		end
	end

	// Sequencer: next state, memory accesses and state updates
	always_comb begin
		logic at_head;
		logic at_tail;
		logic nonempty;
		logic pick_hit;
		logic beats;

		state_d        = state_q;
		cmd_func_d     = cmd_func_q;
		cmd_task_d     = cmd_task_q;
		cmd_pri_d      = cmd_pri_q;
		cmd_en_d       = cmd_en_q;
		old_level_d    = old_level_q;
		ul_prev_d      = ul_prev_q;
		ul_next_d      = ul_next_q;
		ul_at_tail_d   = ul_at_tail_q;
		ul_single_d    = ul_single_q;
		ap_tail_d      = ap_tail_q;
		ap_nonempty_d  = ap_nonempty_q;
		rt_head_d      = rt_head_q;
		rt_tail_d      = rt_tail_q;
		sr_level_d     = sr_level_q;
		ready_bitmap_d = ready_bitmap_q;
		task_ready_d   = task_ready_q;
		pick_d         = pick_q;
		pick_level_d   = pick_level_q;
		pick_valid_d   = pick_valid_q;
		req_d          = req_q;
		out_load       = 1'b0;

		tm_ren   = 1'b0;
		tm_raddr = cmd_task_q;
		tm_wen   = '0;
		tm_waddr = cmd_task_q;
		tm_wdata = '0;
		lm_ren   = 1'b0;
		lm_raddr = cmd_pri_q;
		lm_wen   = '0;
		lm_waddr = cmd_pri_q;
		lm_wdata = '0;

		at_head  = 1'b0;
		at_tail  = 1'b0;
		nonempty = 1'b0;
		pick_hit = pick_valid_q && (pick_q == cmd_task_q);
		beats    = !pick_valid_q || (cmd_pri_q < pick_level_q);

		case (state_q)
			// take a command; ones that cannot apply go straight to the result
			S_IDLE: begin
				if (in_valid) begin
					cmd_func_d = func_t'(func);
					cmd_task_d = task_id;
					cmd_pri_d  = priority_req;
					cmd_en_d   = dispatch_enabled;
					req_d      = 1'b0;
					case (func_t'(func))
						FN_MAKE_READY: begin
							state_d = (task_ok && pri_ok && !task_ready_q[task_id]) ?
								S_AP_RD : S_DONE;
						end
						FN_REMOVE: begin
							state_d = (task_ok && task_ready_q[task_id]) ?
								S_UL_TASK : S_DONE;
						end
						FN_CHG_PRI: begin
							state_d = (task_ok && pri_ok && task_ready_q[task_id]) ?
								S_UL_TASK : S_DONE;
						end
						FN_ROTATE: begin
							state_d = pri_ok ? S_RT_LVL : S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			// unlink: fetch the task's level and links
			S_UL_TASK: begin
				tm_ren   = 1'b1;
				tm_raddr = cmd_task_q;
				state_d  = S_UL_LVL;
			end

			S_UL_LVL: begin
				old_level_d = tm_rdata.level;
				ul_prev_d   = tm_rdata.prev;
				ul_next_d   = tm_rdata.next;
				lm_ren      = 1'b1;
				lm_raddr    = tm_rdata.level;
				state_d     = S_UL_W1;
			end

			// unlink: fix head/tail and the predecessor's next link, or empty the level
			S_UL_W1: begin
				at_head      = (lm_rdata.head == cmd_task_q);
				at_tail      = (lm_rdata.tail == cmd_task_q);
				ul_at_tail_d = at_tail;
				ul_single_d  = at_head && at_tail;
				lm_waddr     = old_level_q;
				if (at_head && at_tail) begin
					ready_bitmap_d[old_level_q] = 1'b0;
				end else begin
					if (at_head) begin
						lm_wen.head   = 1'b1;
						lm_wdata.head = ul_next_q;
					end else begin
						tm_wen.next   = 1'b1;
						tm_waddr      = ul_prev_q;
						tm_wdata.next = ul_next_q;
					end
					if (at_tail) begin
						lm_wen.tail   = 1'b1;
						lm_wdata.tail = ul_prev_q;
					end
				end
				state_d = S_UL_W2;
			end

			// unlink: successor's prev link, then finish remove or append
			S_UL_W2: begin
				if (!ul_single_q && !ul_at_tail_q) begin
					tm_wen.prev   = 1'b1;
					tm_waddr      = ul_next_q;
					tm_wdata.prev = ul_prev_q;
				end
				if (cmd_func_q == FN_REMOVE) begin
					task_ready_d[cmd_task_q] = 1'b0;
					state_d = pick_hit ? S_SR_RD : S_DONE;
				end else begin
					state_d = S_AP_RD;
				end
			end

			// append: fetch the target level
			S_AP_RD: begin
				lm_ren   = 1'b1;
				lm_raddr = cmd_pri_q;
				state_d  = S_AP_W1;
			end

			// append: task entry, level tail (and head when empty)
			S_AP_W1: begin
				nonempty       = ready_bitmap_q[cmd_pri_q];
				ap_tail_d      = lm_rdata.tail;
				ap_nonempty_d  = nonempty;
				tm_wen.level   = 1'b1;
				tm_wen.prev    = nonempty;
				tm_waddr       = cmd_task_q;
				tm_wdata.level = cmd_pri_q;
				tm_wdata.prev  = lm_rdata.tail;
				lm_waddr       = cmd_pri_q;
				lm_wen.tail    = 1'b1;
				lm_wen.head    = !nonempty;
				lm_wdata.tail  = cmd_task_q;
				lm_wdata.head  = cmd_task_q;
				ready_bitmap_d[cmd_pri_q] = 1'b1;
				task_ready_d[cmd_task_q]  = 1'b1;
				state_d = S_AP_W2;
			end

			// append: old tail's next link, then update the pick
			S_AP_W2: begin
				if (ap_nonempty_q) begin
					tm_wen.next   = 1'b1;
					tm_waddr      = ap_tail_q;
					tm_wdata.next = cmd_task_q;
				end
				if ((cmd_func_q == FN_CHG_PRI) && pick_hit) begin
					if (cmd_pri_q >= old_level_q) begin
						state_d = S_SR_RD;
					end else begin
						pick_level_d = cmd_pri_q;
						state_d      = S_DONE;
					end
				end else begin
					if (beats) begin
						pick_d       = cmd_task_q;
						pick_level_d = cmd_pri_q;
						pick_valid_d = 1'b1;
						req_d        = cmd_en_q;
					end
					state_d = S_DONE;
				end
			end

			// search: head of the highest non-empty level
			S_SR_RD: begin
				if (ready_bitmap_q == '0) begin
					pick_d       = '0;
					pick_valid_d = 1'b0;
					req_d        = cmd_en_q;
					state_d      = S_DONE;
				end else begin
					sr_level_d = top_level;
					lm_ren     = 1'b1;
					lm_raddr   = top_level;
					state_d    = S_SR_WB;
				end
			end

			S_SR_WB: begin
				pick_d       = lm_rdata.head;
				pick_level_d = sr_level_q;
				pick_valid_d = 1'b1;
				req_d        = cmd_en_q &&
					((cmd_func_q == FN_REMOVE) || (lm_rdata.head != cmd_task_q));
				state_d      = S_DONE;
			end

			// rotate: fetch the level, then the head's next link
			S_RT_LVL: begin
				lm_ren   = 1'b1;
				lm_raddr = cmd_pri_q;
				state_d  = S_RT_HD;
			end

			S_RT_HD: begin
				if (ready_bitmap_q[cmd_pri_q] && (lm_rdata.head != lm_rdata.tail)) begin
					rt_head_d = lm_rdata.head;
					rt_tail_d = lm_rdata.tail;
					tm_ren    = 1'b1;
					tm_raddr  = lm_rdata.head;
					state_d   = S_RT_W1;
				end else begin
					state_d = S_DONE;
				end
			end

			// rotate: new head/tail, old tail links to old head
			S_RT_W1: begin
				lm_waddr      = cmd_pri_q;
				lm_wen.head   = 1'b1;
				lm_wen.tail   = 1'b1;
				lm_wdata.head = tm_rdata.next;
				lm_wdata.tail = rt_head_q;
				tm_wen.next   = 1'b1;
				tm_waddr      = rt_tail_q;
				tm_wdata.next = rt_head_q;
				if (pick_valid_q && (pick_q == rt_head_q)) begin
					pick_d = tm_rdata.next;
					req_d  = cmd_en_q;
				end
				state_d = S_RT_W2;
			end

			S_RT_W2: begin
				tm_wen.prev   = 1'b1;
				tm_waddr      = rt_head_q;
				tm_wdata.prev = rt_tail_q;
				state_d       = S_DONE;
			end

			// hand the result to the output register
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// result register empties on a taken beat, refills on load
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ready_bitmap_q <= '0;
			task_ready_q   <= '0;
			pick_q         <= '0;
			pick_level_q   <= '0;
			pick_valid_q   <= 1'b0;
			req_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q        <= state_d;
			ready_bitmap_q <= ready_bitmap_d;
			task_ready_q   <= task_ready_d;
			pick_q         <= pick_d;
			pick_level_q   <= pick_level_d;
			pick_valid_q   <= pick_valid_d;
			req_q          <= req_d;
			out_valid_q    <= out_valid_d;
		end
	end

	// Command and scratch payload
	always_ff @(posedge clk) begin
		cmd_func_q    <= cmd_func_d;
		cmd_task_q    <= cmd_task_d;
		cmd_pri_q     <= cmd_pri_d;
		cmd_en_q      <= cmd_en_d;
		old_level_q   <= old_level_d;
		ul_prev_q     <= ul_prev_d;
		ul_next_q     <= ul_next_d;
		ul_at_tail_q  <= ul_at_tail_d;
		ul_single_q   <= ul_single_d;
		ap_tail_q     <= ap_tail_d;
		ap_nonempty_q <= ap_nonempty_d;
		rt_head_q     <= rt_head_d;
		rt_tail_q     <= rt_tail_d;
		sr_level_q    <= sr_level_d;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			sched_task_q       <= pick_q;
			sched_valid_q      <= pick_valid_q;
			dispatch_request_q <= req_q;
		end
	end

	// Checks: pick tracks the bitmap and the ready set
	logic [NUM_LEVELS-1:0] above_pick;
	assign above_pick = ready_bitmap_q & ~({NUM_LEVELS{1'b1}} << pick_level_q);

	a_pick_valid_matches_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pick_valid_q == (ready_bitmap_q != '0)))
		else $error("pick valid disagrees with ready bitmap");

	a_pick_at_top_level: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && pick_valid_q) |->
			(ready_bitmap_q[pick_level_q] && (above_pick == '0)))
		else $error("pick is not at the highest non-empty level");

	a_pick_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && pick_valid_q) |-> task_ready_q[pick_q])
		else $error("pick is not a ready task");

	a_tm_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tm_ren && (tm_wen != '0)))
		else $error("task memory read and written in one cycle");

	a_load_leaves_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("result load did not land");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - priority ready queue scheduler core
// Drives command beats and checks every result beat against a behavioural
// copy of the per-level task queues, the level bitmap and the current pick.
// A short directed sequence is followed by mostly well-formed random
// commands under several idling mixes, and a long result hold-off that
// backs the block up.
// ----------------------------------------------------------------------------
module testbench;
	import prq_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 240;
	localparam int MAX_PRINTS   = 40;

	// Expected contents of one result beat
	typedef struct packed {
		logic [TASK_W-1:0] sched_task;
		logic              sched_valid;
		logic              dispatch_request;
	} sched_beat_t;

	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               in_valid         = 1'b0;
	logic               in_stall;
	func_t              func             = FN_MAKE_READY;
	logic [TASK_W-1:0]  task_id          = '0;
	logic [LEVEL_W-1:0] priority_req     = '0;
	logic               dispatch_enabled = 1'b0;
	logic               out_valid;
	logic               out_stall        = 1'b0;
	logic [TASK_W-1:0]  sched_task;
	logic               sched_valid;
	logic               dispatch_request;

	// Idling controls and hold-off flag
	int unsigned send_pct  = 0;
	int unsigned stall_pct = 0;
	logic        hold_on   = 1'b0;

	// Counters
	int err_cnt       = 0;
	int n_sent        = 0;
	int n_ignored     = 0;
	int n_checked     = 0;
	int n_dispatch    = 0;

	// Shadow of the ready queues
	logic [NUM_LEVELS-1:0] lvl_map;
	logic [TASK_W-1:0]     q_head [NUM_LEVELS];
	logic [TASK_W-1:0]     q_tail [NUM_LEVELS];
	logic [TASK_W-1:0]     nxt    [NUM_TASKS];
	logic [TASK_W-1:0]     prv    [NUM_TASKS];
	logic [LEVEL_W-1:0]    lvl_of [NUM_TASKS];
	logic [NUM_TASKS-1:0]  ready_vec;
	logic [TASK_W-1:0]     top_task;
	logic                  top_valid;

	sched_beat_t sched_expect [$];

	priority_ready_queue_scheduler_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.task_id          (task_id),
		.priority_req     (priority_req),
		.dispatch_enabled (dispatch_enabled),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sched_task       (sched_task),
		.sched_valid      (sched_valid),
		.dispatch_request (dispatch_request)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Queue shadow
	// ------------------------------------------------------------------
	function automatic void q_append(logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] lv);
		if (!lvl_map[lv]) begin
			q_head[lv] = t;
		end else begin
			nxt[q_tail[lv]] = t;
			prv[t] = q_tail[lv];
		end
		q_tail[lv] = t;
		lvl_map[lv] = 1'b1;
	endfunction

	function automatic void q_unlink(logic [TASK_W-1:0] t);
		logic [LEVEL_W-1:0] lv;
		logic               at_head;
		logic               at_tail;
		lv = lvl_of[t];
		at_head = (q_head[lv] == t);
		at_tail = (q_tail[lv] == t);
		if (at_head && at_tail) begin
			lvl_map[lv] = 1'b0;
			return;
		end
		if (at_head)
			q_head[lv] = nxt[t];
		else
			nxt[prv[t]] = nxt[t];
		if (at_tail)
			q_tail[lv] = prv[t];
		else
			prv[nxt[t]] = prv[t];
	endfunction

	// Head of the highest non-empty level
	function automatic void q_search();
		top_valid = 1'b0;
		top_task  = '0;
		for (int lv = 0; lv < NUM_LEVELS; lv++) begin
			if (lvl_map[lv]) begin
				top_task  = q_head[lv];
				top_valid = 1'b1;
				break;
			end
		end
	endfunction

	// Apply one command to the shadow and return the result beat it gives
	function automatic sched_beat_t predict_sched(func_t f, logic [TASK_W-1:0] t,
			logic [LEVEL_W-1:0] lv, logic en);
		sched_beat_t        r;
		logic               req;
		logic               done;
		logic [LEVEL_W-1:0] old_lv;
		logic [TASK_W-1:0]  h;
		req  = 1'b0;
		done = 1'b0;
		case (f)
			FN_MAKE_READY: begin
				if (!ready_vec[t]) begin
					done = 1'b1;
					lvl_of[t] = lv;
					ready_vec[t] = 1'b1;
					q_append(t, lv);
					if (!top_valid || lv < lvl_of[top_task]) begin
						top_task  = t;
						top_valid = 1'b1;
						req = en;
					end
				end
			end
			FN_REMOVE: begin
				if (ready_vec[t]) begin
					done = 1'b1;
					q_unlink(t);
					ready_vec[t] = 1'b0;
					if (top_valid && top_task == t) begin
						q_search();
						req = en;
					end
				end
			end
			FN_CHG_PRI: begin
				if (ready_vec[t]) begin
					done = 1'b1;
					old_lv = lvl_of[t];
					q_unlink(t);
					lvl_of[t] = lv;
					q_append(t, lv);
					if (top_valid && top_task == t) begin
						// pick moved down or sideways: look again
						if (lv >= old_lv) begin
							q_search();
							req = (top_task != t) && en;
						end
					end else if (!top_valid || lv < lvl_of[top_task]) begin
						top_task  = t;
						top_valid = 1'b1;
						req = en;
					end
				end
			end
			default: begin
				// rotate needs two or more tasks in the level
				if (lvl_map[lv] && q_head[lv] != q_tail[lv]) begin
					done = 1'b1;
					h = q_head[lv];
					q_head[lv] = nxt[h];
					nxt[q_tail[lv]] = h;
					prv[h] = q_tail[lv];
					q_tail[lv] = h;
					if (top_valid && top_task == h) begin
						top_task = q_head[lv];
						req = en;
					end
				end
			end
		endcase
		if (!done)
			n_ignored++;
		r.sched_task       = top_valid ? top_task : '0;
		r.sched_valid      = top_valid;
		r.dispatch_request = req;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("%0t: mismatch on %s at beat %0d: got %0d, expected %0d",
				$realtime, what, n_checked, got, want);
	endtask

	// ------------------------------------------------------------------
	// Command side: one beat per call, with optional idle cycles first
	// ------------------------------------------------------------------
	task automatic send_cmd(func_t f, logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] lv,
			logic en);
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		in_valid         <= 1'b1;
		func             <= f;
		task_id          <= t;
		priority_req     <= lv;
		dispatch_enabled <= en;
		do @(posedge clk); while (in_stall);
		sched_expect.push_back(predict_sched(f, t, lv, en));
		n_sent++;
	endtask

	// Mostly legal commands on the live queues, some noise
	task automatic send_random();
		int unsigned        roll;
		int unsigned        mk;
		int                 n_rdy;
		func_t              f;
		logic [TASK_W-1:0]  t;
		logic [LEVEL_W-1:0] lv;
		n_rdy = $countones(ready_vec);
		roll  = $urandom_range(99);
		t     = TASK_W'($urandom_range(NUM_TASKS-1));
		// crowd a few levels so the lists get long
		lv    = $urandom_range(1) ? LEVEL_W'($urandom_range(3))
		                          : LEVEL_W'($urandom_range(NUM_LEVELS-1));
		if (roll < 10) begin
			f = func_t'($urandom_range(3));
		end else begin
			if (n_rdy == 0) begin
				f = FN_MAKE_READY;
			end else begin
				mk = (n_rdy == NUM_TASKS) ? 0 : (n_rdy < 24 ? 45 : 20);
				roll = $urandom_range(99);
				if (roll < mk)
					f = FN_MAKE_READY;
				else if (roll < mk + 20)
					f = FN_REMOVE;
				else if (roll < mk + 45)
					f = FN_CHG_PRI;
				else
					f = FN_ROTATE;
			end
			case (f)
				FN_MAKE_READY:
					while (ready_vec[t]) t = TASK_W'($urandom_range(NUM_TASKS-1));
				FN_REMOVE, FN_CHG_PRI:
					while (!ready_vec[t]) t = TASK_W'($urandom_range(NUM_TASKS-1));
				default: if (top_valid && $urandom_range(1)) lv = lvl_of[top_task];
			endcase
		end
		send_cmd(f, t, lv, $urandom_range(99) < 75);
	endtask

	// ------------------------------------------------------------------
	// Result side: stall driver and checker
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_on)
			out_stall <= 1'b1;
		else
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		sched_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sched_expect.size() == 0) begin
				report_mismatch("unexpected result beat", sched_task, 0);
			end else begin
				want = sched_expect.pop_front();
				if (sched_task !== want.sched_task)
					report_mismatch("sched_task", sched_task, want.sched_task);
				if (sched_valid !== want.sched_valid)
					report_mismatch("sched_valid", sched_valid, want.sched_valid);
				if (dispatch_request !== want.dispatch_request)
					report_mismatch("dispatch_request", dispatch_request,
						want.dispatch_request);
				if (want.dispatch_request)
					n_dispatch++;
			end
			n_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic set_idling(int unsigned s, int unsigned r);
		send_pct  = s;
		stall_pct <= r;
	endtask

	// Corner cases on short lists
	task automatic test_directed();
		set_idling(0, 0);
		send_cmd(FN_REMOVE,     6'd5,  4'd0,  1'b1); // remove of a task not ready
		send_cmd(FN_CHG_PRI,    6'd63, 4'd15, 1'b1); // change of a task not ready
		send_cmd(FN_ROTATE,     6'd0,  4'd0,  1'b1); // rotate of an empty level
		send_cmd(FN_MAKE_READY, 6'd63, 4'd15, 1'b1); // first task, lowest level
		send_cmd(FN_ROTATE,     6'd63, 4'd15, 1'b1); // rotate of a single-task level
		send_cmd(FN_MAKE_READY, 6'd0,  4'd0,  1'b0); // higher level, dispatch off
		send_cmd(FN_MAKE_READY, 6'd0,  4'd3,  1'b1); // double insert
		send_cmd(FN_MAKE_READY, 6'd42, 4'd0,  1'b1); // same level, goes to tail
		send_cmd(FN_MAKE_READY, 6'd21, 4'd15, 1'b1);
		send_cmd(FN_ROTATE,     6'd0,  4'd0,  1'b1); // pick rotated away
		send_cmd(FN_ROTATE,     6'd0,  4'd15, 1'b0); // rotate away from the pick
		send_cmd(FN_CHG_PRI,    6'd42, 4'd0,  1'b1); // pick to tail of own level
		send_cmd(FN_CHG_PRI,    6'd0,  4'd0,  1'b1);
		send_cmd(FN_CHG_PRI,    6'd42, 4'd15, 1'b1); // pick drops to lowest level
		send_cmd(FN_CHG_PRI,    6'd21, 4'd0,  1'b1); // same level as pick: no change
		send_cmd(FN_CHG_PRI,    6'd63, 4'd7,  1'b0);
		send_cmd(FN_REMOVE,     6'd21, 4'd0,  1'b1); // remove a non-pick
		send_cmd(FN_REMOVE,     6'd0,  4'd0,  1'b1); // remove the pick, search
		send_cmd(FN_CHG_PRI,    6'd42, 4'd3,  1'b1); // non-pick overtakes the pick
		send_cmd(FN_CHG_PRI,    6'd42, 4'd3,  1'b1); // alone at its level: same pick
		send_cmd(FN_CHG_PRI,    6'd42, 4'd1,  1'b1); // pick raised, no search
		send_cmd(FN_REMOVE,     6'd63, 4'd0,  1'b1);
		send_cmd(FN_REMOVE,     6'd42, 4'd0,  1'b0); // last task out, no pick
	endtask

	task automatic test_random(int unsigned s, int unsigned r);
		int goal;
		set_idling(s, r);
		goal = (n_sent - n_ignored) + PHASE_ITEMS;
		while ((n_sent - n_ignored) < goal)
			send_random();
	endtask

	// Hold the result side off while commands keep coming
	task automatic test_backpressure();
		set_idling(0, 0);
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
			repeat (30) send_random();
		join
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		lvl_map   = '0;
		ready_vec = '0;
		top_task  = '0;
		top_valid = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(0, 0);
		test_random(47, 0);
		test_random(0, 47);
		test_random(11, 11);
		test_backpressure();
		in_valid <= 1'b0;
		while (sched_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d commands (%0d ignored), %0d result beats, %0d dispatches,",
			n_sent, n_ignored, n_checked, n_dispatch);
		$display("four idling mixes and a %0d-cycle result hold-off.", HOLD_CYCLES);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
